@@ src/aesir_pkg.sv @@
// Shared types, transform codes and GF(2^8) helpers for the AES inverse round unit.
// No dependencies; imported by the lane, merge, top level and checker.
`default_nettype none
package aesir_pkg;

    localparam int unsigned COL_W  = 32;
    localparam int unsigned NCOLS  = 4;
    localparam int unsigned HALF_W = 64;

    typedef logic [1:0]       t_kind;
    typedef logic [COL_W-1:0] t_col;

    localparam t_kind KIND_ARK  = 2'd0;
    localparam t_kind KIND_ISB  = 2'd1;
    localparam t_kind KIND_ISR  = 2'd2;
    localparam t_kind KIND_IMC  = 2'd3;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

@@ src/aes_inverse_round_operations.sv @@
// Channel | dir | handshake          | payload
// input   | in  | i_valid / o_stall  | i_kind, i_state_lo/hi, i_key_lo/hi
// output  | out | o_valid / i_stall  | o_result_lo, o_result_hi
//
// One word per cycle while o_stall is low; each result is registered.
// Four column lanes and the merge stage form a single combinational stage before
// the output register; a skid register holds one word while the output is stalled.
// Synchronous active-low reset clears both valid flags; o_stall is the skid flag.
// Depends on aesir_pkg, aesir_lane, aesir_merge.
`default_nettype none
module aes_inverse_round_operations (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    input  var logic                           i_valid,
    output var logic                           o_stall,
    input  var aesir_pkg::t_kind               i_kind,
    input  var logic [aesir_pkg::HALF_W-1:0]   i_state_lo,
    input  var logic [aesir_pkg::HALF_W-1:0]   i_state_hi,
    input  var logic [aesir_pkg::HALF_W-1:0]   i_key_lo,
    input  var logic [aesir_pkg::HALF_W-1:0]   i_key_hi,
    output var logic                           o_valid,
    input  var logic                           i_stall,
    output var logic [aesir_pkg::HALF_W-1:0]   o_result_lo,
    output var logic [aesir_pkg::HALF_W-1:0]   o_result_hi
);
    import aesir_pkg::*;

    logic [2*HALF_W-1:0] w_state;
    logic [2*HALF_W-1:0] w_key;
    logic [2*HALF_W-1:0] w_res;
    t_col                w_lane [NCOLS];
    logic                w_accept;

    logic                r_out_valid;
    logic [2*HALF_W-1:0] r_out;
    logic                r_skid_valid;
    logic [2*HALF_W-1:0] r_skid;

    assign w_state  = {i_state_hi, i_state_lo};
    assign w_key    = {i_key_hi, i_key_lo};
    assign w_accept = i_valid && !r_skid_valid;

    for (genvar c = 0; c < NCOLS; c++) begin : g_lane
        aesir_lane u_lane (
            .i_kind (i_kind),
            .i_col  (w_state[COL_W*c +: COL_W]),
            .i_key  (w_key[COL_W*c +: COL_W]),
            .o_col  (w_lane[c])
        );
    end

    aesir_merge u_merge (
        .i_kind  (i_kind),
        .i_lane  (w_lane),
        .i_state (w_state),
        .o_state (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_out_valid && i_stall) begin
                r_skid       <= w_res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_result_lo = r_out[HALF_W-1:0];
    assign o_result_hi = r_out[2*HALF_W-1:HALF_W];

endmodule
`default_nettype wire

@@ src/aesir_lane.sv @@
// Lane: AddRoundKey, InvSubBytes, InvMixColumns or copy on a 32-bit column.
// Depends on aesir_pkg.
`default_nettype none
module aesir_lane (
    input  var aesir_pkg::t_kind i_kind,
    input  var aesir_pkg::t_col  i_col,
    input  var aesir_pkg::t_col  i_key,
    output var aesir_pkg::t_col  o_col
);
    import aesir_pkg::*;

    logic [7:0] x1 [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    t_col       w_sub;
    t_col       w_mix;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            x1[r]  = i_col[8*r +: 8];
            x2[r]  = xtime(x1[r]);
            x4[r]  = xtime(x2[r]);
            x8[r]  = xtime(x4[r]);
            m9[r]  = x8[r] ^ x1[r];
            m11[r] = x8[r] ^ x2[r] ^ x1[r];
            m13[r] = x8[r] ^ x4[r] ^ x1[r];
            m14[r] = x8[r] ^ x4[r] ^ x2[r];
            w_sub[8*r +: 8] = INV_SBOX[x1[r]];
        end
        w_mix[7:0]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
        w_mix[15:8]  = m9[0]  ^ m14[1] ^ m11[2] ^ m13[3];
        w_mix[23:16] = m13[0] ^ m9[1]  ^ m14[2] ^ m11[3];
        w_mix[31:24] = m11[0] ^ m13[1] ^ m9[2]  ^ m14[3];
    end

    always_comb begin
        case (i_kind)
            KIND_ARK: o_col = i_col ^ i_key;
            KIND_ISB: o_col = w_sub;
            KIND_IMC: o_col = w_mix;
            default:  o_col = i_col;
        endcase
    end

endmodule
`default_nettype wire

@@ src/aesir_merge.sv @@
// Merge stage: gathers the four lane columns, or applies InvShiftRows to i_state.
// Depends on aesir_pkg.
`default_nettype none
module aesir_merge (
    input  var aesir_pkg::t_kind                       i_kind,
    input  var aesir_pkg::t_col                        i_lane [aesir_pkg::NCOLS],
    input  var logic [aesir_pkg::NCOLS*aesir_pkg::COL_W-1:0] i_state,
    output var logic [aesir_pkg::NCOLS*aesir_pkg::COL_W-1:0] o_state
);
    import aesir_pkg::*;

    logic [NCOLS*COL_W-1:0] w_shift;
    logic [NCOLS*COL_W-1:0] w_lanes;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_lanes[COL_W*c +: COL_W] = i_lane[c];
            for (int r = 0; r < 4; r++) begin
                w_shift[8*(4*((c+r)%4)+r) +: 8] = i_state[8*(4*c+r) +: 8];
            end
        end
    end

    assign o_state = (i_kind == KIND_ISR) ? w_shift : w_lanes;

endmodule
`default_nettype wire

@@ src/aesir_checker.sv @@
// Port-level checker for the AES inverse round unit, bound to the top level.
// Depends on aesir_pkg and aes_inverse_round_operations.
`default_nettype none
module aesir_checker (
    input var logic                         i_clk,
    input var logic                         i_rst_n,
    input var logic                         i_valid,
    input var logic                         o_stall,
    input var aesir_pkg::t_kind             i_kind,
    input var logic [aesir_pkg::HALF_W-1:0] i_state_lo,
    input var logic [aesir_pkg::HALF_W-1:0] i_key_lo,
    input var logic                         o_valid,
    input var logic                         i_stall,
    input var logic [aesir_pkg::HALF_W-1:0] o_result_lo
);
    import aesir_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not idle after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_lo))
        else $error("stalled result changed");

    a_skid_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with empty output");

    a_stall_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |=> !o_stall)
        else $error("stall held after output moved");

    a_add_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (!o_valid || !i_stall) && i_kind == KIND_ARK
        |=> o_valid && o_result_lo == $past(i_state_lo ^ i_key_lo))
        else $error("add round key result wrong");

endmodule

bind aes_inverse_round_operations aesir_checker u_aesir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_kind      (i_kind),
    .i_state_lo  (i_state_lo),
    .i_key_lo    (i_key_lo),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_result_lo (o_result_lo)
);
`default_nettype wire
